### sv/ndc_pkg.sv
// Shared types and constants for the number to digit characters block.
package ndc_pkg;

    localparam int SR_W       = 40;   // ten BCD digits, or the raw value in the top 32 bits
    localparam int DEC_DIGITS = 10;

    localparam logic [4:0] TOP_DEC   = 5'd9;
    localparam logic [4:0] TOP_HEX   = 5'd7;
    localparam logic [4:0] TOP_BIN   = 5'd31;
    localparam logic [4:0] CONV_LAST = 5'd31;

    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_BIN  = 2'd3;

    localparam logic [0:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [0:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_WORK
    } ndc_state_t;

    typedef enum logic [2:0] {
        SR_HOLD,
        SR_LOAD_BIN,
        SR_LOAD_RAW,
        SR_DABBLE,
        SR_SHIFT1,
        SR_SHIFT4
    } sr_op_t;

    typedef struct packed {
        sr_op_t      op;
        logic [31:0] data;
    } sr_ctrl_t;

    typedef struct packed {
        logic [3:0] line;
        logic [6:0] column;
        logic [6:0] code;
        logic       in_range;
        logic       last;
    } char_item_t;

endpackage

### sv/number_to_digit_characters.sv
// Top level: formats a 32-bit number into a run of ASCII digit character items.
//
// Slave side takes one number item (mode in s_tuser) and the master side
// sends one character item per position, most significant digit first,
// with m_tlast on the final one and the on-display flag in m_tuser.
// Signed decimal sends a '+' or '-' item ahead of the magnitude digits.
// Decimal modes first run a double-dabble conversion through the digit shift
// register; hex and binary load it directly.
// The shift register then drops unwanted leading digits one per cycle (up to
// 9 in decimal, 7 in hex, 31 in binary), and one character item leaves per
// cycle while the output register has room.
// The first character follows the conversion in decimal modes and the direct
// load in hex or binary; digits are pushed only after the dropped digits.
// Items are taken one at a time. s_tready is high only between items; the next
// item is taken while the last character still waits in the output register.
// A stalled receiver holds the output register and pauses the sequencer before
// its next push. Reset empties the output register, returns to idle and sets
// the display size to 4 lines by 16 columns. The user writes it with cfg_we
// between items; the block itself does not enforce this.
module number_to_digit_characters
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // line[3:0], start_column[9:4], number[41:10], digit_count[47:42]
    input  logic [47:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_out[3:0], column_out[10:4], char_code[17:11], zero fill above
    output logic [23:0] m_tdata,
    // in_range[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(MAX_DIGITS);

    ndc_pkg::ndc_state_t state_reg;
    ndc_pkg::ndc_state_t state_next;

    logic [3:0]       row_count_reg;
    logic [5:0]       column_count_reg;
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [3:0]       line_reg;
    logic [3:0]       line_next;
    logic [6:0]       col_reg;
    logic [6:0]       col_next;
    logic             zero_reg;
    logic             zero_next;
    logic             neg_reg;
    logic             neg_next;
    logic [CNT_W-1:0] e_reg;
    logic [CNT_W-1:0] e_next;
    logic [4:0]       top_reg;
    logic [4:0]       top_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;

    logic                s_accept;
    logic [1:0]          in_op;
    logic [3:0]          in_line;
    logic [5:0]          in_col;
    logic [31:0]         in_number;
    logic [5:0]          in_count;
    logic [5:0]          n_sat;
    logic [4:0]          e_ext;
    logic                dec_mode;
    logic                push;
    logic                space;
    logic [3:0]          top_nibble;
    logic                top_bit;
    logic [6:0]          digit_char;
    logic                pos_ok;
    ndc_pkg::sr_ctrl_t   sr_ctrl;
    ndc_pkg::char_item_t item_in;
    ndc_pkg::char_item_t item_out;

    assign s_tready  = (state_reg == ndc_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_op     = s_tuser;
    assign in_line   = s_tdata[3:0];
    assign in_col    = s_tdata[9:4];
    assign in_number = s_tdata[41:10];
    assign in_count  = s_tdata[47:42];
    assign n_sat     = (in_count > 6'(MAX_DIGITS)) ? 6'(MAX_DIGITS) : in_count;
    assign e_ext     = 5'(e_reg);
    assign dec_mode  = (mode_reg == ndc_pkg::OP_UDEC) || (mode_reg == ndc_pkg::OP_SDEC);

    always_comb
    begin
        if (mode_reg == ndc_pkg::OP_BIN)
        begin
            digit_char = ndc_pkg::CH_ZERO + {6'd0, top_bit};
        end
        else if (top_nibble < 4'd10)
        begin
            digit_char = ndc_pkg::CH_ZERO + {3'd0, top_nibble};
        end
        else
        begin
            digit_char = ndc_pkg::CH_A + {3'd0, top_nibble} - 7'd10;
        end
    end

    assign pos_ok = (line_reg >= 4'd1) && (line_reg <= row_count_reg) &&
                    (col_reg >= 7'd1) && (col_reg <= {1'b0, column_count_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ndc_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if ((in_op == ndc_pkg::OP_UDEC) || (in_op == ndc_pkg::OP_SDEC))
                    begin
                        state_next = ndc_pkg::ST_CONV;
                    end
                    else if (in_count != 6'd0)
                    begin
                        state_next = ndc_pkg::ST_WORK;
                    end
                end
            end
            ndc_pkg::ST_CONV:
            begin
                if (cnt_reg == ndc_pkg::CONV_LAST)
                begin
                    if (mode_reg == ndc_pkg::OP_SDEC)
                    begin
                        state_next = ndc_pkg::ST_SIGN;
                    end
                    else if (zero_reg)
                    begin
                        state_next = ndc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = ndc_pkg::ST_WORK;
                    end
                end
            end
            ndc_pkg::ST_SIGN:
            begin
                if (space)
                begin
                    state_next = zero_reg ? ndc_pkg::ST_IDLE : ndc_pkg::ST_WORK;
                end
            end
            ndc_pkg::ST_WORK:
            begin
                if (top_reg <= e_ext && space && e_reg == '0)
                begin
                    state_next = ndc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ndc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        zero_next     = zero_reg;
        neg_next      = neg_reg;
        e_next        = e_reg;
        top_next      = top_reg;
        cnt_next      = cnt_reg;
        sr_ctrl.op    = ndc_pkg::SR_HOLD;
        sr_ctrl.data  = in_number;
        push          = 1'b0;
        item_in.line     = line_reg;
        item_in.column   = col_reg;
        item_in.code     = digit_char;
        item_in.in_range = pos_ok;
        item_in.last     = 1'b0;
        case (state_reg)
            ndc_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    mode_next = in_op;
                    line_next = in_line;
                    col_next  = {1'b0, in_col};
                    zero_next = (in_count == 6'd0);
                    neg_next  = in_number[31];
                    e_next    = CNT_W'(n_sat - 6'd1);
                    cnt_next  = 5'd0;
                    case (in_op)
                        ndc_pkg::OP_UDEC:
                        begin
                            top_next   = ndc_pkg::TOP_DEC;
                            sr_ctrl.op = ndc_pkg::SR_LOAD_BIN;
                        end
                        ndc_pkg::OP_SDEC:
                        begin
                            top_next   = ndc_pkg::TOP_DEC;
                            sr_ctrl.op = ndc_pkg::SR_LOAD_BIN;
                            if (in_number[31])
                            begin
                                sr_ctrl.data = ~in_number + 32'd1;
                            end
                        end
                        ndc_pkg::OP_HEX:
                        begin
                            top_next   = ndc_pkg::TOP_HEX;
                            sr_ctrl.op = ndc_pkg::SR_LOAD_RAW;
                        end
                        default:
                        begin
                            top_next   = ndc_pkg::TOP_BIN;
                            sr_ctrl.op = ndc_pkg::SR_LOAD_RAW;
                        end
                    endcase
                end
            end
            ndc_pkg::ST_CONV:
            begin
                sr_ctrl.op = ndc_pkg::SR_DABBLE;
                cnt_next   = cnt_reg + 5'd1;
            end
            ndc_pkg::ST_SIGN:
            begin
                item_in.code = neg_reg ? ndc_pkg::CH_MINUS : ndc_pkg::CH_PLUS;
                item_in.last = zero_reg;
                if (space)
                begin
                    push     = 1'b1;
                    col_next = col_reg + 7'd1;
                end
            end
            ndc_pkg::ST_WORK:
            begin
                item_in.last = (e_reg == '0);
                if (top_reg > e_ext)
                begin
                    // drop digits above the requested count
                    sr_ctrl.op = dec_mode || (mode_reg == ndc_pkg::OP_HEX) ?
                                 ndc_pkg::SR_SHIFT4 : ndc_pkg::SR_SHIFT1;
                    top_next   = top_reg - 5'd1;
                end
                else if (space)
                begin
                    push     = 1'b1;
                    col_next = col_reg + 7'd1;
                    e_next   = e_reg - CNT_W'(1);
                    if (top_reg == e_ext)
                    begin
                        sr_ctrl.op = dec_mode || (mode_reg == ndc_pkg::OP_HEX) ?
                                     ndc_pkg::SR_SHIFT4 : ndc_pkg::SR_SHIFT1;
                        top_next   = top_reg - 5'd1;
                    end
                    else
                    begin
                        // position beyond what 32 bits hold
                        item_in.code = ndc_pkg::CH_ZERO;
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ndc_pkg::ST_IDLE;
            row_count_reg    <= 4'd4;
            column_count_reg <= 6'd16;
            e_reg            <= '0;
            top_reg          <= 5'd0;
            cnt_reg          <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            top_reg   <= top_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                if (cfg_index == ndc_pkg::REG_ROW_COUNT)
                begin
                    row_count_reg <= cfg_data[3:0];
                end
                else if (cfg_index == ndc_pkg::REG_COLUMN_COUNT)
                begin
                    column_count_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        line_reg <= line_next;
        col_reg  <= col_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
    end

    ndc_digit_sr u_digit_sr
    (
        .clk        (clk),
        .ctrl       (sr_ctrl),
        .top_nibble (top_nibble),
        .top_bit    (top_bit)
    );

    ndc_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (item_in),
        .space    (space),
        .ready    (m_tready),
        .valid    (m_tvalid),
        .item_out (item_out)
    );

    assign m_tdata = {6'd0, item_out.code, item_out.column, item_out.line};
    assign m_tuser = item_out.in_range;
    assign m_tlast = item_out.last;

    conv_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ndc_pkg::ST_CONV && cnt_reg != ndc_pkg::CONV_LAST)
        |=> (state_reg == ndc_pkg::ST_CONV))
        else $error("conversion left early");

    last_digit_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ndc_pkg::ST_WORK && push && e_reg == '0)
        |=> (state_reg == ndc_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after last digit");

    raw_load_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (in_op == ndc_pkg::OP_HEX || in_op == ndc_pkg::OP_BIN)
         && in_count != 6'd0)
        |=> (state_reg == ndc_pkg::ST_WORK))
        else $error("hex or binary item did not start emitting");

    push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled character item was overwritten");

endmodule

### sv/ndc_digit_sr.sv
// Digit shift register: double-dabble binary to BCD and MSB-first digit shift-out.
module ndc_digit_sr
(
    input  logic              clk,
    input  ndc_pkg::sr_ctrl_t ctrl,
    output logic [3:0]        top_nibble,
    output logic              top_bit
);

    logic [ndc_pkg::SR_W-1:0] dig_reg;
    logic [ndc_pkg::SR_W-1:0] dig_next;
    logic [31:0]              bin_reg;
    logic [31:0]              bin_next;
    logic [ndc_pkg::SR_W-1:0] adj;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        adj = '0;
        for (int k = 0; k < ndc_pkg::DEC_DIGITS; k++)
        begin
            d = dig_reg[4*k +: 4];
            adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        dig_next = dig_reg;
        bin_next = bin_reg;
        case (ctrl.op)
            ndc_pkg::SR_LOAD_BIN:
            begin
                dig_next = '0;
                bin_next = ctrl.data;
            end
            ndc_pkg::SR_LOAD_RAW:
            begin
                dig_next = {ctrl.data, 8'b0};
            end
            ndc_pkg::SR_DABBLE:
            begin
                dig_next = {adj[ndc_pkg::SR_W-2:0], bin_reg[31]};
                bin_next = {bin_reg[30:0], 1'b0};
            end
            ndc_pkg::SR_SHIFT1:
            begin
                dig_next = {dig_reg[ndc_pkg::SR_W-2:0], 1'b0};
            end
            ndc_pkg::SR_SHIFT4:
            begin
                dig_next = {dig_reg[ndc_pkg::SR_W-5:0], 4'b0};
            end
            default:
            begin
                dig_next = dig_reg;
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    assign top_nibble = dig_reg[ndc_pkg::SR_W-1 -: 4];
    assign top_bit    = dig_reg[ndc_pkg::SR_W-1];

endmodule

### sv/ndc_out_reg.sv
// Output register holding one character item for the master side.
module ndc_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ndc_pkg::char_item_t item_in,
    output logic                space,
    input  logic                ready,
    output logic                valid,
    output ndc_pkg::char_item_t item_out
);

    logic                valid_reg;
    logic                valid_next;
    ndc_pkg::char_item_t item_reg;

    assign space = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

### dv/tb_number_to_digit_characters.sv
// Testbench for number_to_digit_characters: predicts every character item and checks each one.
`timescale 1ns / 1ps

module tb_number_to_digit_characters;

    localparam int MAX_DIGITS = 32;
    localparam int SETTLE_CYCLES = 150;   // covers conversion plus alignment of one item

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // display size as the block should hold it
    logic [3:0] disp_rows;
    logic [5:0] disp_cols;

    ndc_pkg::char_item_t expected_chars[$];
    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    number_to_digit_characters #(
        .MAX_DIGITS(MAX_DIGITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [6:0] digit_char(input logic [1:0] op, input logic [31:0] mag,
                                              input int unsigned e);
        logic [31:0] q;
        logic [3:0]  nib;
        int unsigned k;
        if (op == ndc_pkg::OP_HEX)
        begin
            if (e >= 8)
                return ndc_pkg::CH_ZERO;
            nib = mag[4 * e +: 4];
            return (nib < 10) ? ndc_pkg::CH_ZERO + 7'(nib) : ndc_pkg::CH_A + 7'(nib - 10);
        end
        if (op == ndc_pkg::OP_BIN)
            return (e >= 32) ? ndc_pkg::CH_ZERO : ndc_pkg::CH_ZERO + 7'(mag[e]);
        if (e >= 10)
            return ndc_pkg::CH_ZERO;
        q = mag;
        for (k = 0; k < e; k++)
            q = q / 10;
        return ndc_pkg::CH_ZERO + 7'(q % 10);
    endfunction

    function automatic ndc_pkg::char_item_t make_char(input logic [3:0] ln,
                                                      input int unsigned column,
                                                      input logic [6:0] code);
        ndc_pkg::char_item_t ch;
        ch.line     = ln;
        ch.column   = column[6:0];
        ch.code     = code;
        ch.in_range = (ln >= 1) && (ln <= disp_rows) && (column >= 1) && (column <= disp_cols);
        ch.last     = 1'b0;
        return ch;
    endfunction

    // Queue the characters one number should produce.
    function automatic void predict_chars(input logic [1:0] op, input logic [3:0] ln,
                                          input logic [5:0] col, input logic [31:0] num,
                                          input logic [5:0] cnt);
        int unsigned n;
        int unsigned column;
        int unsigned i;
        int unsigned produced;
        logic [31:0] mag;
        n = (cnt > MAX_DIGITS) ? MAX_DIGITS : cnt;
        column = col;
        mag = num;
        produced = 0;
        if (op == ndc_pkg::OP_SDEC)
        begin
            expected_chars.push_back(make_char(ln, column,
                                     num[31] ? ndc_pkg::CH_MINUS : ndc_pkg::CH_PLUS));
            if (num[31])
                mag = ~num + 32'd1;
            column++;
            produced++;
        end
        for (i = 0; i < n; i++)
        begin
            expected_chars.push_back(make_char(ln, column + i, digit_char(op, mag, n - 1 - i)));
            produced++;
        end
        if (produced != 0)
            expected_chars[$].last = 1'b1;
    endfunction

    task automatic send_number(input logic [1:0] op, input logic [3:0] ln,
                               input logic [5:0] col, input logic [31:0] num,
                               input logic [5:0] cnt);
        int unsigned gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 80);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cnt, num, col, ln};
        do
            @(posedge clk);
        while (!s_tready);
        predict_chars(op, ln, col, num, cnt);
    endtask

    // Drop valid, let every expected character drain, then give the block time to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [5:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ndc_pkg::REG_ROW_COUNT)
            disp_rows = value[3:0];
        else
            disp_cols = value;
    endtask

    task automatic test_directed_cases();
        send_number(ndc_pkg::OP_UDEC, 4'd1, 6'd1, 32'd0, 6'd1);
        send_number(ndc_pkg::OP_UDEC, 4'd1, 6'd1, 32'hFFFF_FFFF, 6'd10);
        send_number(ndc_pkg::OP_UDEC, 4'd2, 6'd5, 32'd12345, 6'd12);   // leading zeros past 10
        send_number(ndc_pkg::OP_UDEC, 4'd1, 6'd1, 32'd7, 6'd0);        // nothing comes out
        send_number(ndc_pkg::OP_UDEC, 4'd5, 6'd16, 32'd99, 6'd2);      // line one past display
        send_number(ndc_pkg::OP_UDEC, 4'd4, 6'd15, 32'd1234, 6'd4);    // runs off the right edge
        send_number(ndc_pkg::OP_SDEC, 4'd1, 6'd1, 32'h8000_0000, 6'd10); // most negative value
        send_number(ndc_pkg::OP_SDEC, 4'd3, 6'd2, 32'h7FFF_FFFF, 6'd10);
        send_number(ndc_pkg::OP_SDEC, 4'd1, 6'd1, 32'd0, 6'd1);
        send_number(ndc_pkg::OP_SDEC, 4'd4, 6'd16, 32'hFFFF_FFFF, 6'd0); // sign alone, last
        send_number(ndc_pkg::OP_SDEC, 4'd2, 6'd3, -32'sd5, 6'd3);
        send_number(ndc_pkg::OP_SDEC, 4'd1, 6'd1, 32'h8000_0000, 6'd12);
        send_number(ndc_pkg::OP_HEX, 4'd1, 6'd1, 32'hDEAD_BEEF, 6'd8);
        send_number(ndc_pkg::OP_HEX, 4'd1, 6'd1, 32'h0123_ABCD, 6'd12);
        send_number(ndc_pkg::OP_HEX, 4'd0, 6'd0, 32'hFFFF_FFFF, 6'd63); // saturates, off display
        send_number(ndc_pkg::OP_HEX, 4'd2, 6'd60, 32'd1, 6'd0);
        send_number(ndc_pkg::OP_BIN, 4'd15, 6'd63, 32'hA5A5_A5A5, 6'd32);
        send_number(ndc_pkg::OP_BIN, 4'd1, 6'd1, 32'hFFFF_FFFF, 6'd33);
        send_number(ndc_pkg::OP_BIN, 4'd4, 6'd1, 32'd5, 6'd4);
        send_number(ndc_pkg::OP_BIN, 4'd1, 6'd1, 32'd0, 6'd0);
    endtask

    task automatic test_register_extremes();
        write_reg(ndc_pkg::REG_ROW_COUNT, 6'd0);
        write_reg(ndc_pkg::REG_COLUMN_COUNT, 6'd0);
        send_number(ndc_pkg::OP_UDEC, 4'd1, 6'd1, 32'd42, 6'd3);
        send_number(ndc_pkg::OP_SDEC, 4'd0, 6'd0, 32'hFFFF_FFF0, 6'd2);
        write_reg(ndc_pkg::REG_ROW_COUNT, 6'h3F);     // upper bits beyond the row field
        write_reg(ndc_pkg::REG_COLUMN_COUNT, 6'd63);
        send_number(ndc_pkg::OP_HEX, 4'd15, 6'd56, 32'hCAFE_F00D, 6'd8);
        send_number(ndc_pkg::OP_BIN, 4'd15, 6'd40, 32'h8000_0001, 6'd32);
        send_number(ndc_pkg::OP_UDEC, 4'd0, 6'd63, 32'd3, 6'd1);
        write_reg(ndc_pkg::REG_ROW_COUNT, 6'd1);
        write_reg(ndc_pkg::REG_COLUMN_COUNT, 6'd1);
        send_number(ndc_pkg::OP_SDEC, 4'd1, 6'd0, 32'd9, 6'd1);
        send_number(ndc_pkg::OP_UDEC, 4'd2, 6'd1, 32'd8, 6'd2);
        write_reg(ndc_pkg::REG_ROW_COUNT, 6'd8);
        write_reg(ndc_pkg::REG_COLUMN_COUNT, 6'd32);
        send_number(ndc_pkg::OP_HEX, 4'd8, 6'd25, 32'h0000_00FF, 6'd8);
        send_number(ndc_pkg::OP_UDEC, 4'd9, 6'd32, 32'd1, 6'd1);
    endtask

    task automatic send_random_number();
        logic [1:0]  op;
        logic [5:0]  col;
        logic [31:0] num;
        logic [5:0]  cnt;
        op = 2'($urandom_range(3));
        col = ($urandom_range(1) != 0) ? 6'($urandom_range(1, 24)) : 6'($urandom_range(63));
        case ($urandom_range(3))
            0: num = $urandom;
            1: num = $urandom_range(0, 999);
            2: num = {1'b1, 31'($urandom)};
            default:
                case ($urandom_range(7))
                    0: num = 32'd0;
                    1: num = 32'd9;
                    2: num = 32'd1_000_000_000;
                    3: num = 32'd999_999_999;
                    4: num = 32'h7FFF_FFFF;
                    5: num = 32'h8000_0000;
                    6: num = 32'hFFFF_FFFF;
                    default: num = 32'd1;
                endcase
        endcase
        case ($urandom_range(9))
            0: cnt = ($urandom_range(1) != 0) ? 6'd0 : 6'($urandom_range(33, 63));
            1, 2: cnt = 6'($urandom_range(11, 32));
            default: cnt = 6'($urandom_range(1, 10));
        endcase
        send_number(op, 4'($urandom_range(15)), col, num, cnt);
    endtask

    task automatic test_random_traffic();
        int unsigned send_pct[4] = '{0, 54, 0, 20};
        int unsigned recv_pct[4] = '{0, 0, 54, 20};
        int unsigned p;
        int unsigned c;
        int unsigned i;
        for (p = 0; p < 4; p++)
        begin
            for (c = 0; c < 2; c++)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                write_reg(ndc_pkg::REG_ROW_COUNT, ($urandom_range(3) != 0) ?
                          6'($urandom_range(1, 8)) : 6'($urandom_range(63)));
                write_reg(ndc_pkg::REG_COLUMN_COUNT, ($urandom_range(3) != 0) ?
                          6'($urandom_range(1, 32)) : 6'($urandom_range(63)));
                send_idle_pct  = send_pct[p];
                recv_stall_pct = recv_pct[p];
                for (i = 0; i < 55; i++)
                    send_random_number();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Result side: random back-pressure and comparison with the oldest expectation.
    always @(posedge clk)
    begin : check_chars
        ndc_pkg::char_item_t got;
        ndc_pkg::char_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.line     = m_tdata[3:0];
            got.column   = m_tdata[10:4];
            got.code     = m_tdata[17:11];
            got.in_range = m_tuser[0];
            got.last     = m_tlast;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected item line %0d col %0d code %h range %b last %b",
                         $time, got.line, got.column, got.code, got.in_range, got.last);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: expected line %0d col %0d code %h range %b last %b, ",
                              "got line %0d col %0d code %h range %b last %b"},
                             $time, want.line, want.column, want.code, want.in_range,
                             want.last, got.line, got.column, got.code, got.in_range,
                             got.last);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        disp_rows      = 4'd4;
        disp_cols      = 6'd16;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= ndc_pkg::REG_ROW_COUNT;
        cfg_data  <= 6'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 48'd0;
        s_tuser   <= ndc_pkg::OP_UDEC;
        m_tready  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
sv/ndc_pkg.sv
sv/ndc_digit_sr.sv
sv/ndc_out_reg.sv
sv/number_to_digit_characters.sv
dv/tb_number_to_digit_characters.sv
